// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/apsp_pkg.sv =====
// Types and constants of the all-pairs shortest path block.
package apsp_pkg;

    localparam int NODE_W    = 7;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int MEM_DEPTH = MAX_NODES * MAX_NODES;
    localparam int DIST_W    = 30;
    localparam int WEIGHT_W  = 16;
    localparam int COUNT_W   = 8;

    localparam logic [DIST_W-1:0]  DIST_INF       = DIST_W'(1000000000);
    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(MAX_NODES);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_SOLVE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [NODE_W-1:0]   src_node;
        logic [NODE_W-1:0]   dst_node;
        logic [WEIGHT_W-1:0] weight;
    } t_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unreachable;
    } t_rsp;

endpackage

// ===== rtl/apsp_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module apsp_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 30,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_ra_addr,
    input  logic [AW-1:0]    i_rb_addr,
    output logic [WIDTH-1:0] o_ra_data,
    output logic [WIDTH-1:0] o_rb_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_ra_data;
    logic [WIDTH-1:0] r_rb_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_ra_data <= r_mem[i_ra_addr];
        r_rb_data <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule

// ===== rtl/all_pairs_shortest_path.sv =====
// Top level: Floyd-Warshall all-pairs shortest paths over a distance matrix in RAM.
// Clear writes every RAM entry; edge writes each direction it lowers (dropped: busy stays low);
// solve makes one relaxation pass over RAM per pivot, over the effective node count
// (one row-start read per source row, one entry per cycle, a drain state per pivot).
// One item at a time: busy is high from acceptance until the cycle before the strobe.
// Synchronous active-low reset clears control and sets node_count to 128; matrix is not cleared.
`include "assert_macros.svh"

module all_pairs_shortest_path (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  apsp_pkg::t_req                   i_req,
    output logic                             o_strobe,
    output apsp_pkg::t_rsp                   o_rsp,
    input  logic                             i_cfg_we,
    input  logic [apsp_pkg::COUNT_W-1:0]     i_cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CLEAR    = 8'b0000_0010,
        S_EDGE_WR1 = 8'b0000_0100,
        S_EDGE_WR2 = 8'b0000_1000,
        S_READ     = 8'b0001_0000,
        S_ROW      = 8'b0010_0000,
        S_COL      = 8'b0100_0000,
        S_DRAIN    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [apsp_pkg::COUNT_W-1:0]  r_node_count;
    logic [apsp_pkg::ADDR_W-1:0]   r_cnt, n_cnt;
    logic [apsp_pkg::NODE_W-1:0]   r_k, n_k, r_i, n_i, r_j, n_j;
    logic [apsp_pkg::NODE_W-1:0]   r_u, n_u, r_v, n_v;
    logic [apsp_pkg::WEIGHT_W-1:0] r_w, n_w;
    logic                          r_inrange, n_inrange;
    logic                          r_lower_b, n_lower_b;
    logic                          r_row_fresh, n_row_fresh;
    logic                          r_drain, n_drain;
    logic [apsp_pkg::DIST_W-1:0]   r_dik;
    logic                          r_p0_vld, n_p0_vld;
    logic [apsp_pkg::ADDR_W-1:0]   r_p0_addr, n_p0_addr;
    logic                          r_s1_vld;
    logic [apsp_pkg::ADDR_W-1:0]   r_s1_addr;
    logic [apsp_pkg::DIST_W-1:0]   r_s1_via, r_s1_dij;
    logic                          r_strobe, n_strobe;
    apsp_pkg::t_rsp                r_rsp, n_rsp;

    logic                          mem_we;
    logic [apsp_pkg::ADDR_W-1:0]   mem_waddr, mem_ra, mem_rb;
    logic [apsp_pkg::DIST_W-1:0]   mem_wdata, mem_rda, mem_rdb;

    logic [apsp_pkg::COUNT_W-1:0]  n_eff;
    logic [apsp_pkg::COUNT_W-1:0]  n_eff_m1;
    logic [apsp_pkg::NODE_W-1:0]   last_node;
    logic                          req_in_range;
    logic [apsp_pkg::DIST_W:0]     path_sum;
    logic [apsp_pkg::DIST_W-1:0]   via;
    logic [apsp_pkg::DIST_W-1:0]   weight_ext;
    logic [apsp_pkg::DIST_W-1:0]   read_dist;

    apsp_ram #(
        .DEPTH (apsp_pkg::MEM_DEPTH),
        .WIDTH (apsp_pkg::DIST_W),
        .AW    (apsp_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_ra_addr (mem_ra),
        .i_rb_addr (mem_rb),
        .o_ra_data (mem_rda),
        .o_rb_data (mem_rdb)
    );

    // clamp node count to 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            n_eff = apsp_pkg::COUNT_W'(1);
        end else if (r_node_count > apsp_pkg::NODE_COUNT_RST) begin
            n_eff = apsp_pkg::NODE_COUNT_RST;
        end else begin
            n_eff = r_node_count;
        end
    end

    assign n_eff_m1  = n_eff - apsp_pkg::COUNT_W'(1);
    assign last_node = n_eff_m1[apsp_pkg::NODE_W-1:0];

    assign req_in_range = (apsp_pkg::COUNT_W'(i_req.src_node) < n_eff) &&
                          (apsp_pkg::COUNT_W'(i_req.dst_node) < n_eff);

    // saturating path sum through the pivot
    assign path_sum   = {1'b0, r_dik} + {1'b0, mem_rda};
    assign via        = (path_sum >= {1'b0, apsp_pkg::DIST_INF}) ?
                        apsp_pkg::DIST_INF : path_sum[apsp_pkg::DIST_W-1:0];
    assign weight_ext = apsp_pkg::DIST_W'(r_w);
    assign read_dist  = r_inrange ? mem_rda : apsp_pkg::DIST_INF;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_u         = r_u;
        n_v         = r_v;
        n_w         = r_w;
        n_inrange   = r_inrange;
        n_lower_b   = r_lower_b;
        n_row_fresh = 1'b0;
        n_drain     = r_drain;
        n_p0_vld    = 1'b0;
        n_p0_addr   = r_p0_addr;
        n_strobe    = 1'b0;
        n_rsp       = '0;
        mem_ra      = {r_i, r_k};
        mem_rb      = {r_i, r_j};

        // write back a relaxed entry from the last stage
        mem_we    = r_s1_vld && (r_s1_via < r_s1_dij);
        mem_waddr = r_s1_addr;
        mem_wdata = r_s1_via;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_u       = i_req.src_node;
                    n_v       = i_req.dst_node;
                    n_w       = i_req.weight;
                    n_inrange = req_in_range;
                    mem_ra    = {i_req.src_node, i_req.dst_node};
                    mem_rb    = {i_req.dst_node, i_req.src_node};
                    unique case (i_req.op)
                        apsp_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_CLEAR;
                        end
                        apsp_pkg::OP_EDGE: begin
                            if (req_in_range) begin
                                n_state = S_EDGE_WR1;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        apsp_pkg::OP_SOLVE: begin
                            n_k     = '0;
                            n_i     = '0;
                            n_state = S_ROW;
                        end
                        apsp_pkg::OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = (r_cnt[apsp_pkg::ADDR_W-1:apsp_pkg::NODE_W] ==
                             r_cnt[apsp_pkg::NODE_W-1:0]) ? '0 : apsp_pkg::DIST_INF;
                n_cnt     = r_cnt + apsp_pkg::ADDR_W'(1);
                if (&r_cnt) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EDGE_WR1: begin
                mem_we    = weight_ext < mem_rda;
                mem_waddr = {r_u, r_v};
                mem_wdata = weight_ext;
                n_lower_b = weight_ext < mem_rdb;
                n_state   = S_EDGE_WR2;
            end
            S_EDGE_WR2: begin
                mem_we    = r_lower_b;
                mem_waddr = {r_v, r_u};
                mem_wdata = weight_ext;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_READ: begin
                n_rsp.distance    = read_dist;
                n_rsp.unreachable = read_dist == apsp_pkg::DIST_INF;
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
            end
            S_ROW: begin
                // fetch the source-to-pivot entry for this row
                mem_ra      = {r_i, r_k};
                n_row_fresh = 1'b1;
                n_j         = '0;
                n_state     = S_COL;
            end
            S_COL: begin
                mem_ra    = {r_k, r_j};
                mem_rb    = {r_i, r_j};
                n_p0_vld  = 1'b1;
                n_p0_addr = {r_i, r_j};
                if (r_j == last_node) begin
                    if (r_i == last_node) begin
                        n_drain = 1'b0;
                        n_state = S_DRAIN;
                    end else begin
                        n_i     = r_i + apsp_pkg::NODE_W'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_j = r_j + apsp_pkg::NODE_W'(1);
                end
            end
            S_DRAIN: begin
                // hold until the pivot's last write lands
                n_drain = 1'b1;
                if (r_drain) begin
                    if (r_k == last_node) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_k     = r_k + apsp_pkg::NODE_W'(1);
                        n_i     = '0;
                        n_state = S_ROW;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= apsp_pkg::NODE_COUNT_RST;
            r_strobe     <= 1'b0;
            r_rsp        <= '0;
            r_row_fresh  <= 1'b0;
            r_p0_vld     <= 1'b0;
            r_s1_vld     <= 1'b0;
            r_drain      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_rsp       <= n_rsp;
            r_row_fresh <= n_row_fresh;
            r_p0_vld    <= n_p0_vld;
            r_s1_vld    <= r_p0_vld;
            r_drain     <= n_drain;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_k       <= n_k;
        r_i       <= n_i;
        r_j       <= n_j;
        r_u       <= n_u;
        r_v       <= n_v;
        r_w       <= n_w;
        r_inrange <= n_inrange;
        r_lower_b <= n_lower_b;
        r_p0_addr <= n_p0_addr;
        r_s1_addr <= r_p0_addr;
        r_s1_via  <= via;
        r_s1_dij  <= mem_rdb;
        if (r_row_fresh) begin
            r_dik <= mem_rda;
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `ASSERT_IMPL(a_no_write_idle, r_state == S_IDLE, !mem_we, "RAM write while idle")
    `ASSERT_IMPL(a_strobe_idle, o_strobe, r_state == S_IDLE, "result strobe while busy")
    `ASSERT_IMPL(a_relax_in_solve, r_s1_vld,
        r_state == S_ROW || r_state == S_COL || r_state == S_DRAIN,
        "relaxation stage valid outside solve")
    `ASSERT_NEXT(a_solve_starts, start && !busy && i_req.op == apsp_pkg::OP_SOLVE,
        r_state == S_ROW, "solve request did not start a row")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the all-pairs shortest path block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 950;
    localparam int GAP_PERCENT   = 12;
    localparam int STALL_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SOLVE_MAX_N   = 40;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        apsp_pkg::t_req               req;
        logic [apsp_pkg::COUNT_W-1:0] cfg_value;
        bit                           typed;
        apsp_pkg::t_rsp               want;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    apsp_pkg::t_req               i_req;
    logic                         o_strobe;
    apsp_pkg::t_rsp               o_rsp;
    logic                         i_cfg_we;
    logic [apsp_pkg::COUNT_W-1:0] i_cfg_wdata;

    // shadow copy of the block's matrix and register
    logic [apsp_pkg::DIST_W-1:0]  shadow_dist [apsp_pkg::MEM_DEPTH];
    logic [apsp_pkg::COUNT_W-1:0] shadow_node_count;

    apsp_pkg::t_rsp expected_distances [$];
    t_stim_row      directed_rows [$];
    int             error_count;
    int             stall_cycles;
    bit             allow_gaps;

    all_pairs_shortest_path dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int unsigned nodes_in_use();
        if (shadow_node_count == '0) return 1;
        if (shadow_node_count > apsp_pkg::MAX_NODES) return apsp_pkg::MAX_NODES;
        return shadow_node_count;
    endfunction

    function automatic logic [apsp_pkg::DIST_W-1:0] path_sum(
        logic [apsp_pkg::DIST_W-1:0] a,
        logic [apsp_pkg::DIST_W-1:0] b
    );
        logic [apsp_pkg::DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, apsp_pkg::DIST_INF}) ?
               apsp_pkg::DIST_INF : s[apsp_pkg::DIST_W-1:0];
    endfunction

    // Update the shadow matrix for one request and return the response it yields.
    function automatic apsp_pkg::t_rsp apply_graph_request(apsp_pkg::t_req req);
        apsp_pkg::t_rsp              rsp;
        int unsigned                 n;
        int unsigned                 ij;
        logic [apsp_pkg::DIST_W-1:0] via;
        logic [apsp_pkg::DIST_W-1:0] w;
        logic [apsp_pkg::DIST_W-1:0] d;
        n   = nodes_in_use();
        rsp = '0;
        w   = apsp_pkg::DIST_W'(req.weight);
        case (req.op)
            apsp_pkg::OP_CLEAR: begin
                for (int t = 0; t < apsp_pkg::MEM_DEPTH; t++)
                    shadow_dist[t] = (t / apsp_pkg::MAX_NODES == t % apsp_pkg::MAX_NODES) ?
                                     '0 : apsp_pkg::DIST_INF;
            end
            apsp_pkg::OP_EDGE: begin
                if (req.src_node < n && req.dst_node < n) begin
                    if (w < shadow_dist[{req.src_node, req.dst_node}])
                        shadow_dist[{req.src_node, req.dst_node}] = w;
                    if (w < shadow_dist[{req.dst_node, req.src_node}])
                        shadow_dist[{req.dst_node, req.src_node}] = w;
                end
            end
            apsp_pkg::OP_SOLVE: begin
                for (int unsigned k = 0; k < n; k++)
                    for (int unsigned i = 0; i < n; i++)
                        for (int unsigned j = 0; j < n; j++) begin
                            ij  = i * apsp_pkg::MAX_NODES + j;
                            via = path_sum(shadow_dist[i * apsp_pkg::MAX_NODES + k],
                                           shadow_dist[k * apsp_pkg::MAX_NODES + j]);
                            if (via < shadow_dist[ij]) shadow_dist[ij] = via;
                        end
            end
            default: begin
                d = apsp_pkg::DIST_INF;
                if (req.src_node < n && req.dst_node < n)
                    d = shadow_dist[{req.src_node, req.dst_node}];
                rsp.distance    = d;
                rsp.unreachable = (d == apsp_pkg::DIST_INF);
            end
        endcase
        return rsp;
    endfunction

    function automatic void req_row(apsp_pkg::t_op op, int src, int dst, int w, bit typed,
                                    logic [apsp_pkg::DIST_W-1:0] want_dist, logic unr);
        t_stim_row r;
        r.kind             = ROW_REQ;
        r.req.op           = op;
        r.req.src_node     = apsp_pkg::NODE_W'(src);
        r.req.dst_node     = apsp_pkg::NODE_W'(dst);
        r.req.weight       = apsp_pkg::WEIGHT_W'(w);
        r.cfg_value        = '0;
        r.typed            = typed;
        r.want.distance    = want_dist;
        r.want.unreachable = unr;
        directed_rows      = {directed_rows, r};
    endfunction

    function automatic void cfg_row(int value);
        t_stim_row r;
        r.kind        = ROW_CFG;
        r.req         = '0;
        r.cfg_value   = apsp_pkg::COUNT_W'(value);
        r.typed       = 1'b0;
        r.want        = '0;
        directed_rows = {directed_rows, r};
    endfunction

    // Entered and left at a falling edge; leaves start high for the caller.
    task automatic send_request(apsp_pkg::t_req req, bit typed, apsp_pkg::t_rsp typed_rsp);
        apsp_pkg::t_rsp predicted;
        apsp_pkg::t_rsp want_rsp;
        while (allow_gaps && $urandom_range(99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted          = apply_graph_request(req);
        want_rsp           = typed ? typed_rsp : predicted;
        expected_distances = {expected_distances, want_rsp};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_distances.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_node_count(logic [apsp_pkg::COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we          <= 1'b0;
        shadow_node_count  = value;
    endtask

    always @(posedge i_clk) begin : check_responses
        apsp_pkg::t_rsp want;
        if (i_rst_n && o_strobe) begin
            if (expected_distances.size() == 0) begin
                $display("%0t: unexpected response, expected none, %s %0d unreachable %0b",
                         $time, "actual distance", o_rsp.distance, o_rsp.unreachable);
                error_count++;
            end else begin
                want = expected_distances.pop_front();
                if (o_rsp.distance !== want.distance) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want.distance, o_rsp.distance);
                    error_count++;
                end
                if (o_rsp.unreachable !== want.unreachable) begin
                    $display("%0t: unreachable mismatch, expected %0b, actual %0b",
                             $time, want.unreachable, o_rsp.unreachable);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        apsp_pkg::t_req               rq;
        apsp_pkg::t_rsp               none;
        int unsigned                  n;
        int                           sent;
        int                           phase_len;
        int                           pick;
        bit                           solve_ok;
        logic [apsp_pkg::COUNT_W-1:0] count_value;

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_req             = '0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        error_count       = 0;
        stall_cycles      = 0;
        allow_gaps        = 1'b1;
        shadow_node_count = apsp_pkg::NODE_COUNT_RST;
        none              = '0;
        for (int t = 0; t < apsp_pkg::MEM_DEPTH; t++) shadow_dist[t] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the reset node count
        req_row(apsp_pkg::OP_CLEAR, 0, 0, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 0, 0, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 0, 127, 0, 1, apsp_pkg::DIST_INF, 1'b1);
        req_row(apsp_pkg::OP_READ, 127, 127, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_EDGE, 0, 127, 65535, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 127, 0, 0, 1, apsp_pkg::DIST_W'(65535), 1'b0);
        req_row(apsp_pkg::OP_EDGE, 127, 0, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 0, 127, 0, 1, '0, 1'b0);
        // self loop never beats the zero diagonal
        req_row(apsp_pkg::OP_EDGE, 5, 5, 7, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 5, 5, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_EDGE, 3, 4, 100, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_EDGE, 4, 3, 200, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 3, 4, 0, 0, '0, 1'b0);
        cfg_row(4);
        req_row(apsp_pkg::OP_CLEAR, 0, 0, 0, 1, '0, 1'b0);
        // node index past the count: edge dropped, read unreachable
        req_row(apsp_pkg::OP_EDGE, 1, 5, 9, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 1, 5, 0, 1, apsp_pkg::DIST_INF, 1'b1);
        req_row(apsp_pkg::OP_READ, 5, 1, 0, 1, apsp_pkg::DIST_INF, 1'b1);
        req_row(apsp_pkg::OP_EDGE, 0, 1, 10, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_EDGE, 1, 2, 20, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_EDGE, 2, 3, 30, 0, '0, 1'b0);
        req_row(apsp_pkg::OP_SOLVE, 0, 0, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 0, 3, 0, 0, '0, 1'b0);
        // zero count acts as one node
        cfg_row(0);
        req_row(apsp_pkg::OP_READ, 0, 0, 0, 1, '0, 1'b0);
        req_row(apsp_pkg::OP_READ, 0, 1, 0, 1, apsp_pkg::DIST_INF, 1'b1);
        req_row(apsp_pkg::OP_SOLVE, 0, 0, 0, 1, '0, 1'b0);
        // count saturates; clear reached past the nodes that were in use
        cfg_row(255);
        req_row(apsp_pkg::OP_READ, 100, 101, 0, 1, apsp_pkg::DIST_INF, 1'b1);
        req_row(apsp_pkg::OP_READ, 127, 127, 0, 1, '0, 1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                wait_drained();
                write_node_count(directed_rows[r].cfg_value);
            end else begin
                send_request(directed_rows[r].req, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // hold every new phase until all responses are back
            wait_drained();
            pick = $urandom_range(99);
            if (pick < 10)      count_value = apsp_pkg::COUNT_W'($urandom_range(1));
            else if (pick < 60) count_value = apsp_pkg::COUNT_W'($urandom_range(8, 2));
            else if (pick < 85) count_value = apsp_pkg::COUNT_W'($urandom_range(20, 9));
            else if (pick < 92)
                count_value = apsp_pkg::COUNT_W'($urandom_range(SOLVE_MAX_N, 21));
            else if (pick < 95) count_value = apsp_pkg::COUNT_W'(apsp_pkg::MAX_NODES);
            else if (pick < 97) count_value = '1;
            else
                count_value = apsp_pkg::COUNT_W'($urandom_range(255, SOLVE_MAX_N + 1));
            write_node_count(count_value);
            n        = nodes_in_use();
            solve_ok = (n <= SOLVE_MAX_N);
            if ($urandom_range(2) == 0) begin
                rq = '{op: apsp_pkg::OP_CLEAR, src_node: '0, dst_node: '0, weight: '0};
                send_request(rq, 1'b0, none);
                sent++;
            end
            phase_len = $urandom_range(60, 20);
            for (int p = 0; p < phase_len && sent < RANDOM_ITEMS; p++) begin
                allow_gaps = !(sent >= 300 && sent < 500);
                pick = $urandom_range(99);
                if (pick < 1)                   rq.op = apsp_pkg::OP_CLEAR;
                else if (pick < 4 && solve_ok)  rq.op = apsp_pkg::OP_SOLVE;
                else if (pick < 52)             rq.op = apsp_pkg::OP_EDGE;
                else                            rq.op = apsp_pkg::OP_READ;
                if ($urandom_range(99) < 85) begin
                    rq.src_node = apsp_pkg::NODE_W'($urandom_range(n - 1));
                    rq.dst_node = apsp_pkg::NODE_W'($urandom_range(n - 1));
                end else begin
                    rq.src_node = apsp_pkg::NODE_W'($urandom_range(apsp_pkg::MAX_NODES - 1));
                    rq.dst_node = apsp_pkg::NODE_W'($urandom_range(apsp_pkg::MAX_NODES - 1));
                end
                pick = $urandom_range(99);
                if (pick < 25)      rq.weight = apsp_pkg::WEIGHT_W'($urandom_range(50, 1));
                else if (pick < 30) rq.weight = '0;
                else if (pick < 35) rq.weight = '1;
                else                rq.weight = apsp_pkg::WEIGHT_W'($urandom_range(65535));
                send_request(rq, 1'b0, none);
                sent++;
            end
        end

        allow_gaps = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_ram.sv
rtl/all_pairs_shortest_path.sv
verif/tb.sv
